### hw/rtl/pild_pkg.sv
// ----------------------------------------------------------------------------
// pild_pkg: shared types and constants of the packed index table row dot
// Item kinds, the saturation bounds of the row accumulator and the control
// groups passed between the lookup, accumulate and row scaling sections.
// ----------------------------------------------------------------------------
`default_nettype none

package pild_pkg;

    // item kinds carried in tuser
    localparam logic [1:0] MODE_TABLE = 2'd0;
    localparam logic [1:0] MODE_SCALE = 2'd1;
    localparam logic [1:0] MODE_ROW   = 2'd2;

    localparam int MODE_W       = 2;
    localparam int TADDR_W      = 14;
    localparam int TVAL_W       = 8;
    localparam int BSCALE_W     = 32;
    localparam int IDX_BYTES_W  = 24;
    localparam int HALF_W       = 16;
    localparam int SUM_W        = 16;
    localparam int ACC_W        = 64;
    localparam int NCOLS_W      = 7;
    localparam int IDX_W        = 6;
    localparam int STAGES       = 4;
    localparam int IN_TDATA_W   = 96;

    localparam logic [NCOLS_W-1:0] NCOLS_RESET = 7'd64;

    localparam logic [ACC_W-1:0] ACC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ACC_W-1:0] ACC_MIN = 64'h8000_0000_0000_0000;

    // request issued to the table banks when a row item is taken
    typedef struct packed {
        logic              valid;
        logic              last;
        logic              blkend;
        logic [HALF_W-1:0] half;
    } lu_ctl_t;

    // finished column block handed to the accumulate stage
    typedef struct packed {
        logic                valid;
        logic                last;
        logic [SUM_W-1:0]    sum;
        logic [BSCALE_W-1:0] scale;
        logic [HALF_W-1:0]   half;
    } blk_res_t;

    // side information carried along the row scaling pipeline
    typedef struct packed {
        logic       neg;
        logic       zero_f;
        logic       inf_f;
        logic [4:0] expo;
    } rs_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/pild_lookup.sv
// ----------------------------------------------------------------------------
// pild_lookup: banked table store, block scale store and block sum
// Four table banks, one per stage, are read together for each row item; the
// block sum collects the four bytes and a finished block leaves with its scale.
// ----------------------------------------------------------------------------
`default_nettype none

module pild_lookup
    import pild_pkg::*;
#(
    parameter int MAX_COLUMNS   = 64,
    parameter int BLOCK_COLUMNS = 32
)
(
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  en,
    input  wire                                  tab_we,
    input  wire [TADDR_W-1:0]                    tab_waddr,
    input  wire [TVAL_W-1:0]                     tab_wdata,
    input  wire                                  scl_we,
    input  wire                                  scl_slot,
    input  wire [BSCALE_W-1:0]                   scl_wdata,
    input  wire lu_ctl_t                         rd_ctl,
    input  wire [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] rd_col,
    input  wire [IDX_BYTES_W-1:0]                rd_idx,
    input  wire [(((MAX_COLUMNS + BLOCK_COLUMNS - 1) / BLOCK_COLUMNS) > 1 ?
                  $clog2((MAX_COLUMNS + BLOCK_COLUMNS - 1) / BLOCK_COLUMNS) : 1)-1:0] rd_blk,
    output blk_res_t                             res
);

    localparam int NUM_BLOCKS  = (MAX_COLUMNS + BLOCK_COLUMNS - 1) / BLOCK_COLUMNS;
    localparam int BLK_W       = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int BANK_DEPTH  = MAX_COLUMNS * 64;
    localparam int BANK_AW     = $clog2(BANK_DEPTH);

    wire  [STAGES-1:0][TVAL_W-1:0] lut_rd;
    logic                          tab_col_ok;
    logic [BANK_AW-1:0]            tab_bank_addr;

    logic [BSCALE_W-1:0] scl_mem [NUM_BLOCKS];
    logic [BSCALE_W-1:0] scl_rd_reg;

    logic              b_valid_reg;
    logic              b_last_reg;
    logic              b_blkend_reg;
    logic [HALF_W-1:0] b_half_reg;

    logic [SUM_W-1:0]  block_sum_reg;
    logic [SUM_W-1:0]  block_sum_next;

    logic                c_valid_reg;
    logic                c_last_reg;
    logic [SUM_W-1:0]    c_sum_reg;
    logic [BSCALE_W-1:0] c_scale_reg;
    logic [HALF_W-1:0]   c_half_reg;

    assign tab_col_ok    = int'(tab_waddr[13:8]) < MAX_COLUMNS;
    assign tab_bank_addr = BANK_AW'({tab_waddr[13:8], tab_waddr[5:0]});

    // one bank per stage, addressed by column and entry
    for (genvar s = 0; s < STAGES; s++)
    begin : g_bank
        logic [TVAL_W-1:0]  mem [BANK_DEPTH];
        logic [TVAL_W-1:0]  rd_q;
        logic [BANK_AW-1:0] rd_addr;

        assign rd_addr   = BANK_AW'({rd_col, rd_idx[IDX_W*s +: IDX_W]});
        assign lut_rd[s] = rd_q;

        always_ff @(posedge clk)
        begin
            if (tab_we && tab_col_ok && (tab_waddr[7:6] == 2'(s)))
            begin
                mem[tab_bank_addr] <= tab_wdata;
            end
            if (rd_ctl.valid)
            begin
                rd_q <= mem[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scl_we && (int'(scl_slot) < NUM_BLOCKS))
        begin
            scl_mem[BLK_W'(scl_slot)] <= scl_wdata;
        end
        if (rd_ctl.valid)
        begin
            scl_rd_reg <= scl_mem[rd_blk];
        end
    end

    // four sign-extended bytes into the wrapping block sum
    always_comb
    begin
        block_sum_next = block_sum_reg
                       + {{(SUM_W-TVAL_W){lut_rd[0][TVAL_W-1]}}, lut_rd[0]}
                       + {{(SUM_W-TVAL_W){lut_rd[1][TVAL_W-1]}}, lut_rd[1]}
                       + {{(SUM_W-TVAL_W){lut_rd[2][TVAL_W-1]}}, lut_rd[2]}
                       + {{(SUM_W-TVAL_W){lut_rd[3][TVAL_W-1]}}, lut_rd[3]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            block_sum_reg <= '0;
        end
        else if (en)
        begin
            b_valid_reg <= rd_ctl.valid;
            c_valid_reg <= b_valid_reg && b_blkend_reg;
            if (b_valid_reg)
            begin
                block_sum_reg <= b_blkend_reg ? '0 : block_sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_last_reg   <= rd_ctl.last;
            b_blkend_reg <= rd_ctl.blkend;
            b_half_reg   <= rd_ctl.half;
            c_last_reg   <= b_last_reg;
            c_sum_reg    <= block_sum_next;
            c_scale_reg  <= scl_rd_reg;
            c_half_reg   <= b_half_reg;
        end
    end

    assign res = {c_valid_reg, c_last_reg, c_sum_reg, c_scale_reg, c_half_reg};

endmodule

`default_nettype wire

### hw/rtl/pild_row_scale.sv
// ----------------------------------------------------------------------------
// pild_row_scale: accumulator times half-precision row scale
// Five stage pipeline: magnitude and decode, split multiply, product merge,
// rounding add, alignment shift; saturation and sign are applied at the exit.
// ----------------------------------------------------------------------------
`default_nettype none

module pild_row_scale
    import pild_pkg::*;
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 en,
    input  wire                 in_valid,
    input  wire [ACC_W-1:0]     in_acc,
    input  wire [HALF_W-1:0]    in_half,
    output logic                out_valid,
    output logic [ACC_W-1:0]    out_result
);

    logic [4:0]  ex;
    logic [9:0]  man;
    rs_ctl_t     s1_ctl_next;

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    rs_ctl_t     s1_ctl_reg, s2_ctl_reg, s3_ctl_reg, s4_ctl_reg, s5_ctl_reg;

    logic [ACC_W-1:0] s1_mag_reg;
    logic [10:0]      s1_m_reg;
    logic [42:0]      p0_next, p1_next;
    logic [42:0]      s2_p0_reg, s2_p1_reg;
    logic [74:0]      prod_next;
    logic [74:0]      s3_prod_reg;
    logic [4:0]       rsh;
    logic [75:0]      rnd;
    logic [75:0]      q_next;
    logic [75:0]      s4_q_reg;
    logic [4:0]       s4_rsh;
    logic [79:0]      v_next;
    logic [79:0]      s5_v_reg;
    logic [ACC_W-1:0] limit;
    logic             sat;
    logic [ACC_W-1:0] mag_o;

    assign ex  = in_half[14:10];
    assign man = in_half[9:0];

    always_comb
    begin
        s1_ctl_next.neg    = in_half[15] ^ in_acc[ACC_W-1];
        s1_ctl_next.zero_f = (ex == 5'd31) && ((man != '0) || (in_acc == '0));
        s1_ctl_next.inf_f  = (ex == 5'd31) && (man == '0) && (in_acc != '0);
        // subnormal halves share the scale of the smallest normal exponent
        s1_ctl_next.expo   = (ex == '0) ? 5'd1 : ex;
    end

    assign p0_next   = s1_mag_reg[31:0] * s1_m_reg;
    assign p1_next   = s1_mag_reg[63:32] * s1_m_reg;
    assign prod_next = {s2_p1_reg, 32'd0} + 75'(s2_p0_reg);

    // exponents below 25 shift right by 25 - expo with round half up on magnitude
    assign rsh    = 5'd25 - s3_ctl_reg.expo;
    assign rnd    = (s3_ctl_reg.expo < 5'd25) ? (76'd1 << (rsh - 5'd1)) : '0;
    assign q_next = {1'b0, s3_prod_reg} + rnd;
    assign s4_rsh = 5'd25 - s4_ctl_reg.expo;

    always_comb
    begin
        if (s4_ctl_reg.expo < 5'd25)
        begin
            v_next = {4'd0, s4_q_reg >> s4_rsh};
        end
        else
        begin
            v_next = {4'd0, s4_q_reg} << (s4_ctl_reg.expo - 5'd25);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ctl_reg  <= s1_ctl_next;
            s1_mag_reg  <= in_acc[ACC_W-1] ? (ACC_W'(0) - in_acc) : in_acc;
            s1_m_reg    <= (ex == '0) ? {1'b0, man} : {1'b1, man};
            s2_ctl_reg  <= s1_ctl_reg;
            s2_p0_reg   <= p0_next;
            s2_p1_reg   <= p1_next;
            s3_ctl_reg  <= s2_ctl_reg;
            s3_prod_reg <= prod_next;
            s4_ctl_reg  <= s3_ctl_reg;
            s4_q_reg    <= q_next;
            s5_ctl_reg  <= s4_ctl_reg;
            s5_v_reg    <= v_next;
        end
    end

    assign limit = s5_ctl_reg.neg ? ACC_MIN : ACC_MAX;
    assign sat   = (s5_v_reg[79:64] != '0) || (s5_v_reg[63:0] > limit);
    assign mag_o = (sat || s5_ctl_reg.inf_f) ? limit : s5_v_reg[63:0];

    assign out_valid  = s5_valid_reg;
    assign out_result = s5_ctl_reg.zero_f ? '0 :
                        s5_ctl_reg.neg    ? (ACC_W'(0) - mag_o) : mag_o;

endmodule

`default_nettype wire

### hw/rtl/packed_index_lut_row_dot.sv
// ----------------------------------------------------------------------------
// packed_index_lut_row_dot: row dot product by table lookup on 6-bit indices
// Loads signed table bytes and block scales, then streams rows of index
// quadruples and emits one scaled, saturated dot product per row.
// ----------------------------------------------------------------------------
// One input transaction is taken every cycle, whatever its kind: table and
// scale writes go straight into the stores, and a row item reads four table
// banks (one per stage) and the block scale store in the same cycle, so the
// single read port of each bank sets the rate at one item per cycle. Input is
// held off only while a finished row result reaches the end of the scaling
// pipeline and the output register still holds an untaken result.
// Table entries and block scales must be written before a row reads them.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_index_lut_row_dot
    import pild_pkg::*;
#(
    parameter int MAX_COLUMNS   = 64,
    parameter int BLOCK_COLUMNS = 32
)
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cfg_we,
    input  wire [NCOLS_W-1:0]       cfg_wdata,     // num_columns
    input  wire                     s_axis_tvalid,
    output logic                    s_axis_tready,
    // table_address[13:0], table_value[21:14], scale_slot[22], block_scale[54:23],
    // index_bytes[78:55], row_scale[94:79], zero[95]
    input  wire [IN_TDATA_W-1:0]    s_axis_tdata,
    input  wire [MODE_W-1:0]        s_axis_tuser,  // mode[1:0]
    output logic                    m_axis_tvalid,
    input  wire                     m_axis_tready,
    output logic [ACC_W-1:0]        m_axis_tdata   // row_result[63:0]
);

    localparam int NUM_BLOCKS = (MAX_COLUMNS + BLOCK_COLUMNS - 1) / BLOCK_COLUMNS;
    localparam int CIDX_W     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int BP_W       = (BLOCK_COLUMNS > 1) ? $clog2(BLOCK_COLUMNS) : 1;
    localparam int CW2        = (CIDX_W + 1 > 8) ? CIDX_W + 1 : 8;

    logic [MODE_W-1:0]  mode;
    logic               accept;
    logic               row_take;
    logic               en;

    logic [NCOLS_W-1:0] ncols_reg;
    logic [CIDX_W-1:0]  col_reg;
    logic [BP_W-1:0]    bpos_reg;
    logic [BLK_W-1:0]   blk_reg;

    logic [CW2-1:0]     col_plus;
    logic [CW2-1:0]     ncols_raw;
    logic [CW2-1:0]     ncols_eff;
    logic               row_last;
    logic               blk_last;

    lu_ctl_t            rd_ctl;
    blk_res_t           blk_res;

    logic signed [47:0] d_prod_next;
    logic               d_valid_reg;
    logic               d_last_reg;
    logic [HALF_W-1:0]  d_half_reg;
    logic [47:0]        d_prod_reg;

    logic [ACC_W-1:0]   row_accum_reg;
    logic [ACC_W-1:0]   prod_ext;
    logic [ACC_W-1:0]   acc_sum;
    logic               acc_ovf;
    logic [ACC_W-1:0]   acc_sat;

    logic               e_valid_reg;
    logic [ACC_W-1:0]   e_acc_reg;
    logic [HALF_W-1:0]  e_half_reg;

    logic               rs_valid;
    logic [ACC_W-1:0]   rs_result;

    logic               out_valid_reg;
    logic [ACC_W-1:0]   out_data_reg;

    assign mode     = s_axis_tuser;
    assign en       = !(out_valid_reg && !m_axis_tready && rs_valid);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign row_take = accept && (mode == MODE_ROW);

    // effective column count: zero acts as one, large values clamp to the store
    assign col_plus  = CW2'(col_reg) + CW2'(1);
    assign ncols_raw = CW2'(ncols_reg);

    always_comb
    begin
        priority if (ncols_raw == '0)
        begin
            ncols_eff = CW2'(1);
        end
        else if (ncols_raw > CW2'(MAX_COLUMNS))
        begin
            ncols_eff = CW2'(MAX_COLUMNS);
        end
        else
        begin
            ncols_eff = ncols_raw;
        end
    end

    assign row_last = col_plus >= ncols_eff;
    assign blk_last = bpos_reg == BP_W'(BLOCK_COLUMNS - 1);

    assign rd_ctl.valid  = row_take;
    assign rd_ctl.last   = row_last;
    assign rd_ctl.blkend = row_last || blk_last;
    assign rd_ctl.half   = s_axis_tdata[94:79];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncols_reg <= NCOLS_RESET;
        end
        else if (cfg_we)
        begin
            ncols_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            bpos_reg <= '0;
            blk_reg  <= '0;
        end
        else if (row_take)
        begin
            if (row_last)
            begin
                col_reg  <= '0;
                bpos_reg <= '0;
                blk_reg  <= '0;
            end
            else
            begin
                col_reg <= col_reg + CIDX_W'(1);
                if (blk_last)
                begin
                    bpos_reg <= '0;
                    blk_reg  <= blk_reg + BLK_W'(1);
                end
                else
                begin
                    bpos_reg <= bpos_reg + BP_W'(1);
                end
            end
        end
    end

    pild_lookup #(
        .MAX_COLUMNS   (MAX_COLUMNS),
        .BLOCK_COLUMNS (BLOCK_COLUMNS)
    ) u_lookup (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .tab_we    (accept && (mode == MODE_TABLE)),
        .tab_waddr (s_axis_tdata[13:0]),
        .tab_wdata (s_axis_tdata[21:14]),
        .scl_we    (accept && (mode == MODE_SCALE)),
        .scl_slot  (s_axis_tdata[22]),
        .scl_wdata (s_axis_tdata[54:23]),
        .rd_ctl    (rd_ctl),
        .rd_col    (col_reg),
        .rd_idx    (s_axis_tdata[78:55]),
        .rd_blk    (blk_reg),
        .res       (blk_res)
    );

    // block sum times block scale
    assign d_prod_next = $signed(blk_res.sum) * $signed(blk_res.scale);

    // saturating add into the row accumulator
    assign prod_ext = {{(ACC_W-48){d_prod_reg[47]}}, d_prod_reg};
    assign acc_sum  = row_accum_reg + prod_ext;
    assign acc_ovf  = (row_accum_reg[ACC_W-1] == prod_ext[ACC_W-1])
                   && (acc_sum[ACC_W-1] != row_accum_reg[ACC_W-1]);
    assign acc_sat  = acc_ovf ? (row_accum_reg[ACC_W-1] ? ACC_MIN : ACC_MAX) : acc_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            row_accum_reg <= '0;
        end
        else if (en)
        begin
            d_valid_reg <= blk_res.valid;
            e_valid_reg <= d_valid_reg && d_last_reg;
            if (d_valid_reg)
            begin
                row_accum_reg <= d_last_reg ? '0 : acc_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_last_reg <= blk_res.last;
            d_half_reg <= blk_res.half;
            d_prod_reg <= d_prod_next;
            e_acc_reg  <= acc_sat;
            e_half_reg <= d_half_reg;
        end
    end

    pild_row_scale u_row_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (e_valid_reg),
        .in_acc     (e_acc_reg),
        .in_half    (e_half_reg),
        .out_valid  (rs_valid),
        .out_result (rs_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en && rs_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && rs_valid)
        begin
            out_data_reg <= rs_result;
        end
    end

    assign s_axis_tready = en;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // input is only held off by a row result blocked at the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && rs_valid))
        else $error("input stalled without a blocked row result");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(col_reg) < MAX_COLUMNS) && (int'(blk_reg) < NUM_BLOCKS))
        else $error("column or block counter out of range");

    a_row_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (row_take && row_last) |=> ((col_reg == '0) && (bpos_reg == '0) && (blk_reg == '0)))
        else $error("counters not cleared after a row end");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (en && rs_valid) |=> (m_axis_tvalid && (m_axis_tdata == $past(rs_result))))
        else $error("row result not captured in the output register");

endmodule

`default_nettype wire
